[rtl/pce_pkg.sv]
package pce_pkg;

	// Width of the saturating count of encoded characters.
	localparam int COUNT_WIDTH = 16;

	localparam int BYTE_W      = 8;
	localparam int KEY_W       = 16;
	localparam int OUT_COUNT_W = 16;

	localparam int LETTER_MOD = 26;
	localparam int DIGIT_MOD  = 10;

	localparam logic [BYTE_W-1:0] UPPER_FIRST = 8'd65;
	localparam logic [BYTE_W-1:0] UPPER_LAST  = 8'd90;
	localparam logic [BYTE_W-1:0] LOWER_FIRST = 8'd97;
	localparam logic [BYTE_W-1:0] LOWER_LAST  = 8'd122;
	localparam logic [BYTE_W-1:0] DIGIT_FIRST = 8'd48;
	localparam logic [BYTE_W-1:0] DIGIT_LAST  = 8'd57;

	localparam logic [BYTE_W-1:0] NUL_CHAR = 8'd0;

	// End-of-message marker "__EOM__" followed by a NUL terminator.
	localparam int EOM_LEN = 7;
	localparam int EOM_IDX_W = $clog2(EOM_LEN + 1);
	localparam logic [EOM_IDX_W-1:0] EOM_NUL_IDX = EOM_IDX_W'(EOM_LEN);

	typedef logic [4:0] letter_res_t;
	typedef logic [3:0] digit_res_t;

	// Key reduced to its residues, as seen by the character encoder.
	typedef struct packed {
		letter_res_t letter;
		digit_res_t  digit;
	} key_res_t;

	typedef letter_res_t letter_tab_t [256];
	typedef digit_res_t  digit_tab_t  [256];

	// Residue of (i * weight) for every byte value i, built by stepping.
	function automatic letter_tab_t build_letter_tab(input int step);
		letter_tab_t t;
		int r;
		r = 0;
		for (int i = 0; i < 256; i++) begin
			t[i] = letter_res_t'(r);
			r = r + step;
			if (r >= LETTER_MOD) begin
				r = r - LETTER_MOD;
			end
		end
		return t;
	endfunction

	function automatic digit_tab_t build_digit_tab(input int step);
		digit_tab_t t;
		int r;
		r = 0;
		for (int i = 0; i < 256; i++) begin
			t[i] = digit_res_t'(r);
			r = r + step;
			if (r >= DIGIT_MOD) begin
				r = r - DIGIT_MOD;
			end
		end
		return t;
	endfunction

	function automatic logic [BYTE_W-1:0] eom_char(input logic [EOM_IDX_W-1:0] idx);
		logic [BYTE_W-1:0] c;
		unique case (idx)
			EOM_IDX_W'(0), EOM_IDX_W'(1), EOM_IDX_W'(5), EOM_IDX_W'(6): c = 8'd95;
			EOM_IDX_W'(2): c = 8'd69;
			EOM_IDX_W'(3): c = 8'd79;
			EOM_IDX_W'(4): c = 8'd77;
			default: c = NUL_CHAR;
		endcase
		return c;
	endfunction

endpackage

[rtl/pce_in_if.sv]
interface pce_in_if;
	import pce_pkg::*;

	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] text_byte;
	logic              end_of_text;

	modport source (output valid, output text_byte, output end_of_text, input ready);
	modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

[rtl/pce_out_if.sv]
interface pce_out_if;
	import pce_pkg::*;

	logic                   valid;
	logic                   ready;
	logic [BYTE_W-1:0]      cipher_byte;
	logic                   last_of_run;
	logic [OUT_COUNT_W-1:0] encoded_count;

	modport source (output valid, output cipher_byte, output last_of_run,
		output encoded_count, input ready);
	modport sink   (input valid, input cipher_byte, input last_of_run,
		input encoded_count, output ready);
endinterface

[rtl/pce_key_reg.sv]
module pce_key_reg
	import pce_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             we,
	input  logic [KEY_W-1:0] wdata,
	output key_res_t         key_res
);

	localparam letter_tab_t LO_LETTER = build_letter_tab(1);
	localparam letter_tab_t HI_LETTER = build_letter_tab(256 % LETTER_MOD);
	localparam digit_tab_t  LO_DIGIT  = build_digit_tab(1);
	localparam digit_tab_t  HI_DIGIT  = build_digit_tab(256 % DIGIT_MOD);

	logic [5:0] letter_sum;
	logic [4:0] digit_sum;
	key_res_t   res_d;
	key_res_t   key_res_q;

	// Each key byte contributes its own residue; the two add to less than
	// twice the modulus, so one subtract finishes the reduction.
	always_comb begin
		letter_sum = {1'b0, LO_LETTER[wdata[7:0]]} + {1'b0, HI_LETTER[wdata[15:8]]};
		digit_sum  = {1'b0, LO_DIGIT[wdata[7:0]]} + {1'b0, HI_DIGIT[wdata[15:8]]};
		if (letter_sum >= 6'(LETTER_MOD)) begin
			res_d.letter = 5'(letter_sum - 6'(LETTER_MOD));
		end else begin
			res_d.letter = letter_sum[4:0];
		end
		if (digit_sum >= 5'(DIGIT_MOD)) begin
			res_d.digit = 4'(digit_sum - 5'(DIGIT_MOD));
		end else begin
			res_d.digit = digit_sum[3:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_res_q <= '0;
		end else if (we) begin
			key_res_q <= res_d;
		end
	end

	assign key_res = key_res_q;

endmodule

[rtl/pce_char_encode.sv]
module pce_char_encode
	import pce_pkg::*;
(
	input  logic [BYTE_W-1:0] text_byte,
	input  key_res_t          key_res,
	input  letter_res_t       letter_phase,
	input  digit_res_t        digit_phase,
	output logic [BYTE_W-1:0] cipher_byte,
	output logic              encoded
);

	logic [5:0]        letter_shift_raw;
	logic [4:0]        letter_shift;
	logic [4:0]        digit_shift_raw;
	logic [3:0]        digit_shift;
	logic [BYTE_W-1:0] base;
	logic [BYTE_W-1:0] offset;
	logic [5:0]        letter_pos;
	logic [4:0]        digit_pos;
	logic              is_upper;
	logic              is_lower;
	logic              is_digit;

	always_comb begin
		letter_shift_raw = {1'b0, key_res.letter} + {1'b0, letter_phase};
		letter_shift = (letter_shift_raw >= 6'(LETTER_MOD)) ?
			5'(letter_shift_raw - 6'(LETTER_MOD)) : letter_shift_raw[4:0];
		digit_shift_raw = {1'b0, key_res.digit} + {1'b0, digit_phase};
		digit_shift = (digit_shift_raw >= 5'(DIGIT_MOD)) ?
			4'(digit_shift_raw - 5'(DIGIT_MOD)) : digit_shift_raw[3:0];

		is_upper = (text_byte >= UPPER_FIRST) && (text_byte <= UPPER_LAST);
		is_lower = (text_byte >= LOWER_FIRST) && (text_byte <= LOWER_LAST);
		is_digit = (text_byte >= DIGIT_FIRST) && (text_byte <= DIGIT_LAST);

		if (is_upper) begin
			base = UPPER_FIRST;
		end else if (is_lower) begin
			base = LOWER_FIRST;
		end else begin
			base = DIGIT_FIRST;
		end
		offset = text_byte - base;

		letter_pos = {1'b0, offset[4:0]} + {1'b0, letter_shift};
		if (letter_pos >= 6'(LETTER_MOD)) begin
			letter_pos = letter_pos - 6'(LETTER_MOD);
		end
		digit_pos = {1'b0, offset[3:0]} + {1'b0, digit_shift};
		if (digit_pos >= 5'(DIGIT_MOD)) begin
			digit_pos = digit_pos - 5'(DIGIT_MOD);
		end

		encoded = is_upper || is_lower || is_digit;
		if (is_upper || is_lower) begin
			cipher_byte = base + BYTE_W'(letter_pos);
		end else if (is_digit) begin
			cipher_byte = base + BYTE_W'(digit_pos);
		end else begin
			cipher_byte = text_byte;
		end
	end

endmodule

[rtl/progressive_caesar_encrypt_unit.sv]
// Progressive Caesar encoder, one message byte per transfer.
//
// Channels: text_in carries text_byte and end_of_text; cipher_out carries
// cipher_byte, last_of_run and encoded_count. Both use valid/ready, and a
// transfer happens on a rising clock edge where both are high. Write the key
// via shift_key_we/shift_key_wdata only while idle, unchecked by the block.
//
// Data path: an item waits in the input register and moves into the output
// register once that register is free or being emptied; the result is
// offered from the output register. A data byte yields one result, and a
// new byte can be taken every cycle while the receiver keeps up. An
// end-of-text item yields eight results, the marker "__EOM__" and a NUL
// carrying last_of_run and the count; it holds the input register until the
// NUL is loaded, while the marker sequencer steps through the results.
//
// Reset clears the key, the letter and digit phases, the count and all valid
// flags. When the receiver stalls, the output register holds its result;
// one more item waits in the input register, after which text_in.ready drops.
module progressive_caesar_encrypt_unit
	import pce_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	pce_in_if.sink           text_in,
	pce_out_if.source        cipher_out,
	input  logic             shift_key_we,
	input  logic [KEY_W-1:0] shift_key_wdata
);

	key_res_t key_res;

	pce_key_reg u_key_reg (
		.clk     (clk),
		.arst_n  (arst_n),
		.we      (shift_key_we),
		.wdata   (shift_key_wdata),
		.key_res (key_res)
	);

	// Input stage.
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              eot_s1;

	// Message state.
	letter_res_t          letter_phase_q;
	digit_res_t           digit_phase_q;
	logic [COUNT_WIDTH-1:0] encoded_total_q;
	logic [EOM_IDX_W-1:0] eom_idx_q;

	// Output register.
	logic                   out_valid_q;
	logic [BYTE_W-1:0]      out_byte_q;
	logic                   out_last_q;
	logic [OUT_COUNT_W-1:0] out_count_q;

	logic [BYTE_W-1:0] enc_byte;
	logic              enc_hit;
	logic              out_load;
	logic              eom_final;
	logic              s1_done;
	logic              in_fire;
	logic [31:0]       total_ext;

	pce_char_encode u_char_encode (
		.text_byte    (byte_s1),
		.key_res      (key_res),
		.letter_phase (letter_phase_q),
		.digit_phase  (digit_phase_q),
		.cipher_byte  (enc_byte),
		.encoded      (enc_hit)
	);

	// A result moves into the output register whenever that register is
	// free or is being emptied in the same cycle.
	assign out_load  = valid_s1 && (!out_valid_q || cipher_out.ready);
	assign eom_final = eot_s1 && (eom_idx_q == EOM_NUL_IDX);
	// The input register empties after a data byte, or after the NUL of an
	// end-of-text sequence.
	assign s1_done   = out_load && (!eot_s1 || eom_final);
	assign text_in.ready = !valid_s1 || s1_done;
	assign in_fire   = text_in.valid && text_in.ready;
	assign total_ext = 32'(encoded_total_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text_in.ready) begin
			valid_s1 <= text_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			byte_s1 <= text_in.text_byte;
			eot_s1  <= text_in.end_of_text;
		end
	end

	// Phases advance on every data byte; the whole message state restarts
	// as the terminating NUL goes out.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			letter_phase_q  <= '0;
			digit_phase_q   <= '0;
			encoded_total_q <= '0;
			eom_idx_q       <= '0;
		end else if (out_load) begin
			if (eot_s1) begin
				if (eom_final) begin
					letter_phase_q  <= '0;
					digit_phase_q   <= '0;
					encoded_total_q <= '0;
					eom_idx_q       <= '0;
				end else begin
					eom_idx_q <= eom_idx_q + EOM_IDX_W'(1);
				end
			end else begin
				letter_phase_q <= (letter_phase_q == letter_res_t'(LETTER_MOD - 1)) ?
					'0 : letter_phase_q + letter_res_t'(1);
				digit_phase_q <= (digit_phase_q >= digit_res_t'(DIGIT_MOD - 2)) ?
					'0 : digit_phase_q + digit_res_t'(2);
				if (enc_hit && (encoded_total_q != '1)) begin
					encoded_total_q <= encoded_total_q + COUNT_WIDTH'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (cipher_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			if (eot_s1) begin
				out_byte_q  <= eom_char(eom_idx_q);
				out_last_q  <= eom_final;
				out_count_q <= eom_final ? total_ext[OUT_COUNT_W-1:0] : '0;
			end else begin
				out_byte_q  <= enc_byte;
				out_last_q  <= 1'b0;
				out_count_q <= '0;
			end
		end
	end

	assign cipher_out.valid         = out_valid_q;
	assign cipher_out.cipher_byte   = out_byte_q;
	assign cipher_out.last_of_run   = out_last_q;
	assign cipher_out.encoded_count = out_count_q;

	// The marker sequencer only runs while an end-of-text item is held.
	a_eom_idx_owned: assert property (@(posedge clk) disable iff (!arst_n)
		(eom_idx_q != '0) |-> (valid_s1 && eot_s1))
		else $error("marker index advanced without an end-of-text item");

	a_letter_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		letter_phase_q <= letter_res_t'(LETTER_MOD - 1))
		else $error("letter phase out of range");

	a_digit_phase_even: assert property (@(posedge clk) disable iff (!arst_n)
		(digit_phase_q[0] == 1'b0) && (digit_phase_q < digit_res_t'(DIGIT_MOD)))
		else $error("digit phase not an even residue");

	a_last_is_nul: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_last_q) |-> (out_byte_q == NUL_CHAR))
		else $error("last flag on a byte other than the terminator");

	a_restart_after_nul: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && eom_final) |=>
		(letter_phase_q == '0 && digit_phase_q == '0 && encoded_total_q == '0))
		else $error("message state not restarted after the terminator");

endmodule

[tb/progressive_caesar_encrypt_unit_tb.sv]
`timescale 1ns / 1ps

// Testbench for the progressive Caesar encoder.
//
// The bench drives text_in and cipher_out through the block's own interfaces
// and keeps a software copy of the encoder: the key, the letter and digit
// phases and the saturating count. Every input transfer that the block
// accepts is run through that copy, which queues the cipher bytes it
// expects. Every output transfer is compared field by field with the oldest
// queued byte.
//
// The run goes through these parts:
//  - a directed walk over a stimulus table, with the reset key. It covers
//    the case boundaries of letters and digits, the NUL byte, high bytes and
//    empty messages. Where a row's result is plain, the table gives it.
//  - several key settings, the extremes among them, each with random
//    messages. A setting can end in the middle of a message, so the next
//    key takes over on an open message.
//  - one setting where the receiver holds off for a long stretch while the
//    sender keeps offering bytes, so that the block backs up into text_in.
module progressive_caesar_encrypt_unit_tb;
	import pce_pkg::*;

	localparam int CLK_HALF       = 5;
	localparam int RESET_CYCLES   = 7;
	// Margin to wait once nothing is pending any more.
	localparam int SETTLE_CYCLES  = 8;
	// A long receiver hold-off for the backpressure setting.
	localparam int LONG_HOLD      = 60;
	// Longest span with no transfer that a correct run can show: the long
	// hold-off plus overlapping long gaps on both sides, with margin.
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int PHASE_ITEMS    = 22;
	localparam int NUM_PHASES     = 6;
	localparam int PRESSURE_PHASE = 2;
	localparam int STEADY_PHASE   = 3;

	localparam logic [8*EOM_LEN-1:0] EOM_TEXT = "__EOM__";

	// Key for each random setting. The last setting takes a random key.
	localparam logic [KEY_W-1:0] PHASE_KEY [NUM_PHASES] = '{
		16'hFFFF, 16'd25, 16'd26, 16'd0, 16'd9, 16'd1
	};

	// One expected output transfer.
	typedef struct packed {
		logic [BYTE_W-1:0]      cbyte;
		logic                   last;
		logic [OUT_COUNT_W-1:0] count;
	} cipher_t;

	// One row of the directed table. When known is set, want holds the
	// expected cipher byte for a data byte, or the expected count on the
	// terminating NUL for an end-of-text row.
	typedef struct packed {
		logic [BYTE_W-1:0]      text;
		logic                   eot;
		logic                   known;
		logic [OUT_COUNT_W-1:0] want;
	} probe_t;

	localparam int DIR_N = 20;

	// All rows run with the reset key of zero, so a letter at position p
	// moves by p and a digit by 2p mod 10.
	localparam probe_t DIRECTED [DIR_N] = '{
		//  text    eot   known want
		'{"A",   1'b0, 1'b1, "A"},     // first upper-case letter, no shift
		'{"z",   1'b0, 1'b1, "a"},     // last lower-case letter wraps around
		'{"0",   1'b0, 1'b1, "4"},     // digit at position 2 moves by 4
		'{"9",   1'b0, 1'b1, "5"},     // last digit wraps around
		'{"@",   1'b0, 1'b1, "@"},     // just below upper case
		'{"[",   1'b0, 1'b1, "["},     // just above upper case
		'{8'h60, 1'b0, 1'b1, 8'h60},   // just below lower case
		'{"{",   1'b0, 1'b1, "{"},     // just above lower case
		'{"/",   1'b0, 1'b1, "/"},     // just below the digits
		'{":",   1'b0, 1'b1, ":"},     // just above the digits
		'{8'h00, 1'b0, 1'b1, 8'h00},   // NUL as data passes through
		'{8'hFF, 1'b0, 1'b1, 8'hFF},   // high bytes pass through
		'{8'h80, 1'b0, 1'b1, 8'h80},
		'{"Z",   1'b0, 1'b1, "M"},     // position 13
		'{"a",   1'b0, 1'b1, "o"},     // position 14
		'{8'h00, 1'b1, 1'b1, 16'd6},   // six letters and digits so far
		'{8'hFF, 1'b1, 1'b1, 16'd0},   // empty message, byte ignored
		'{"Q",   1'b0, 1'b1, "Q"},     // position restarted at zero
		'{"0",   1'b0, 1'b1, "2"},
		'{8'h5A, 1'b1, 1'b1, 16'd2}
	};

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic             shift_key_we;
	logic [KEY_W-1:0] shift_key_wdata;

	pce_in_if  text_in ();
	pce_out_if cipher_out ();

	progressive_caesar_encrypt_unit dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.text_in         (text_in),
		.cipher_out      (cipher_out),
		.shift_key_we    (shift_key_we),
		.shift_key_wdata (shift_key_wdata)
	);

	always #CLK_HALF clk = ~clk;

	// Software copy of the encoder state, all zero after reset.
	logic [KEY_W-1:0]       model_key        = '0;
	letter_res_t            model_letter_pos = '0;
	digit_res_t             model_digit_pos  = '0;
	logic [COUNT_WIDTH-1:0] model_total      = '0;

	cipher_t pending_cipher [$];
	int      accepted_items = 0;
	int      errors         = 0;
	int      quiet_cycles   = 0;

	// Controls for the two traffic processes, set by the main sequence.
	bit src_idle_en   = 1'b1;
	bit sink_idle_en  = 1'b1;
	bit sink_hold_req = 1'b0;

	// Works out what one accepted input transfer must produce and queues it.
	// A typed value from the directed table takes the place of the computed
	// cipher byte, or of the count on the terminating NUL.
	function automatic void predict_cipher(input logic [BYTE_W-1:0] b, input logic eot,
			input logic typed, input logic [OUT_COUNT_W-1:0] typed_val);
		cipher_t r;
		int      s;
		int      first;
		int      modulus;
		logic    hit;
		r = '0;
		if (eot) begin
			// The marker goes out first, most significant character first.
			for (int k = 0; k < EOM_LEN; k++) begin
				r.cbyte = EOM_TEXT[8*(EOM_LEN-1-k) +: 8];
				pending_cipher.push_back(r);
			end
			r.cbyte = NUL_CHAR;
			r.last  = 1'b1;
			r.count = typed ? typed_val : OUT_COUNT_W'(model_total);
			pending_cipher.push_back(r);
			model_letter_pos = '0;
			model_digit_pos  = '0;
			model_total      = '0;
		end else begin
			hit     = 1'b1;
			first   = 0;
			modulus = LETTER_MOD;
			s       = int'(model_key) % LETTER_MOD + int'(model_letter_pos);
			if (b >= UPPER_FIRST && b <= UPPER_LAST) begin
				first = int'(UPPER_FIRST);
			end else if (b >= LOWER_FIRST && b <= LOWER_LAST) begin
				first = int'(LOWER_FIRST);
			end else if (b >= DIGIT_FIRST && b <= DIGIT_LAST) begin
				first   = int'(DIGIT_FIRST);
				modulus = DIGIT_MOD;
				s       = int'(model_key) % DIGIT_MOD + int'(model_digit_pos);
			end else begin
				hit = 1'b0;
			end
			r.cbyte = hit ? BYTE_W'(first + (int'(b) - first + s) % modulus) : b;
			if (typed) begin
				r.cbyte = typed_val[BYTE_W-1:0];
			end
			pending_cipher.push_back(r);
			// The count saturates instead of wrapping.
			if (hit && model_total != '1) begin
				model_total = model_total + COUNT_WIDTH'(1);
			end
			// Every data byte advances the position, encoded or not.
			model_letter_pos = letter_res_t'((int'(model_letter_pos) + 1) % LETTER_MOD);
			model_digit_pos  = digit_res_t'((int'(model_digit_pos) + 2) % DIGIT_MOD);
		end
	endfunction

	function automatic void compare_field(input string field, input int want, input int got);
		if (want != got) begin
			$display("%0t ns: %s mismatch, expected %0d, got %0d", $time, field, want, got);
			errors++;
		end
	endfunction

	// Mostly letters and digits, since those exercise the shift logic; the
	// rest is any byte at all.
	function automatic logic [BYTE_W-1:0] random_text_byte(input bit alnum_only);
		int pick;
		pick = alnum_only ? $urandom_range(0, 7) : $urandom_range(0, 9);
		case (pick)
			0, 1, 2: return BYTE_W'(int'(UPPER_FIRST) + $urandom_range(0, LETTER_MOD - 1));
			3, 4, 5: return BYTE_W'(int'(LOWER_FIRST) + $urandom_range(0, LETTER_MOD - 1));
			6, 7:    return BYTE_W'(int'(DIGIT_FIRST) + $urandom_range(0, DIGIT_MOD - 1));
			default: return BYTE_W'($urandom_range(0, 255));
		endcase
	endfunction

	// Gap length in cycles: usually none, sometimes a few, now and then long.
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 19);
		if (r < 12) begin
			return 0;
		end else if (r < 18) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	// Input and output monitor. Inputs are driven and outputs registered on
	// the rising edge with nonblocking assignments, so the values seen here
	// are the ones that were in place when the edge came.
	always @(posedge clk) begin
		cipher_t want;
		if (arst_n) begin
			if (shift_key_we) begin
				model_key = shift_key_wdata;
			end
			if (text_in.valid && text_in.ready) begin
				if (accepted_items < DIR_N) begin
					predict_cipher(text_in.text_byte, text_in.end_of_text,
						DIRECTED[accepted_items].known, DIRECTED[accepted_items].want);
				end else begin
					predict_cipher(text_in.text_byte, text_in.end_of_text, 1'b0, '0);
				end
				accepted_items++;
			end
			if (cipher_out.valid && cipher_out.ready) begin
				if (pending_cipher.size() == 0) begin
					$display("%0t ns: unexpected transfer, cipher_byte %0d last_of_run %0d encoded_count %0d",
						$time, cipher_out.cipher_byte, cipher_out.last_of_run,
						cipher_out.encoded_count);
					errors++;
				end else begin
					want = pending_cipher.pop_front();
					compare_field("cipher_byte", int'(want.cbyte),
						int'(cipher_out.cipher_byte));
					compare_field("last_of_run", int'(want.last),
						int'(cipher_out.last_of_run));
					compare_field("encoded_count", int'(want.count),
						int'(cipher_out.encoded_count));
				end
			end
		end
	end

	// Watchdog: a hung handshake ends the run instead of letting it spin.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((text_in.valid && text_in.ready) || (cipher_out.valid && cipher_out.ready)) begin
				quiet_cycles <= 0;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("progressive_caesar_encrypt_unit_tb: errors");
				$finish;
			end
		end
	end

	// Receiver. Each pass either drops ready for a random gap or, when the
	// main sequence asks for it, for one long hold-off, and then raises it again.
	initial begin
		int n;
		cipher_out.ready <= 1'b0;
		@(posedge clk);
		forever begin
			if (sink_hold_req) begin
				sink_hold_req = 1'b0;
				cipher_out.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else begin
				n = sink_idle_en ? idle_len() : 0;
				if (n > 0) begin
					cipher_out.ready <= 1'b0;
					repeat (n) @(posedge clk);
				end
			end
			cipher_out.ready <= 1'b1;
			@(posedge clk);
		end
	end

	// Offers one item and returns at the edge where it is transferred. valid
	// is only raised here, so back-to-back items keep it high without a dip.
	task automatic send_item(input logic [BYTE_W-1:0] b, input logic eot);
		text_in.valid       <= 1'b1;
		text_in.text_byte   <= b;
		text_in.end_of_text <= eot;
		do @(posedge clk); while (!text_in.ready);
	endtask

	task automatic pause_source();
		int n;
		n = src_idle_en ? idle_len() : 0;
		if (n > 0) begin
			text_in.valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// Stops offering and waits until every queued result has been seen.
	task automatic settle();
		text_in.valid <= 1'b0;
		do @(posedge clk); while (pending_cipher.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_key(input logic [KEY_W-1:0] k);
		shift_key_we    <= 1'b1;
		shift_key_wdata <= k;
		@(posedge clk);
		shift_key_we    <= 1'b0;
	endtask

	// Random messages until the budget runs out. Some are empty or short,
	// most are 3 to 14 bytes, and the budget may run out in the middle
	// of one, which leaves that message open for the next key.
	task automatic send_messages(input int budget);
		int len;
		while (budget > 0) begin
			len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 14);
			for (int k = 0; k < len && budget > 0; k++) begin
				send_item(random_text_byte(1'b0), 1'b0);
				budget--;
				pause_source();
			end
			if (budget > 0) begin
				send_item(BYTE_W'($urandom_range(0, 255)), 1'b1);
				budget--;
				pause_source();
			end
		end
	endtask

	initial begin
		logic [KEY_W-1:0] k;
		text_in.valid       <= 1'b0;
		text_in.text_byte   <= '0;
		text_in.end_of_text <= 1'b0;
		shift_key_we        <= 1'b0;
		shift_key_wdata     <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed walk with the reset key.
		for (int i = 0; i < DIR_N; i++) begin
			send_item(DIRECTED[i].text, DIRECTED[i].eot);
			pause_source();
		end
		settle();

		// Random messages under a series of keys. One setting runs with no
		// gaps at all; another holds the receiver off while the sender keeps
		// offering, so the block fills and stalls text_in.
		for (int p = 0; p < NUM_PHASES; p++) begin
			k = (p == NUM_PHASES - 1) ? KEY_W'($urandom) : PHASE_KEY[p];
			write_key(k);
			src_idle_en  = (p != PRESSURE_PHASE) && (p != STEADY_PHASE);
			sink_idle_en = (p != STEADY_PHASE);
			if (p == PRESSURE_PHASE) begin
				sink_hold_req = 1'b1;
			end
			send_messages(PHASE_ITEMS);
			settle();
		end

		if (errors == 0 && pending_cipher.size() == 0) begin
			$display("progressive_caesar_encrypt_unit_tb: clean");
		end else begin
			$display("progressive_caesar_encrypt_unit_tb: errors");
		end
		$finish;
	end

endmodule

[filelist.f]
rtl/pce_pkg.sv
rtl/pce_in_if.sv
rtl/pce_out_if.sv
rtl/pce_key_reg.sv
rtl/pce_char_encode.sv
rtl/progressive_caesar_encrypt_unit.sv
tb/progressive_caesar_encrypt_unit_tb.sv
